### design/jetp_pkg.sv
// Shared types and constants for the Julia escape-time pixel block.
// Used by the register file, the core and the top level; depends on nothing.
package jetp_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTRACT_THR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_C_REAL      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG      = 3'd5;

	localparam logic [30:0]        RST_HALF_WIDTH  = 31'd33554432;
	localparam logic [30:0]        RST_PIXEL_STEP  = 31'd140102;
	localparam logic [30:0]        RST_ATTRACT_THR = 31'd1678;
	localparam logic [15:0]        RST_MAX_COLOR   = 16'd15;
	localparam logic signed [31:0] RST_C_REAL      = -32'sd2046820;
	localparam logic signed [31:0] RST_C_IMAG      = 32'sd12499026;

	// Escape radius squared, 100 in Q16.48.
	localparam logic [63:0] ESCAPE_MAG = 64'd100 << 48;

	typedef struct packed {
		logic [30:0]        half_width;
		logic [30:0]        pixel_step;
		logic [30:0]        attract_threshold;
		logic [15:0]        max_color;
		logic signed [31:0] c_real;
		logic signed [31:0] c_imag;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### design/jetp_in_if.sv
// Input channel carrying one pixel coordinate pair per transaction.
// Depends on nothing.
interface jetp_in_if;
	logic       valid;
	logic       ready;
	logic [9:0] col;
	logic [9:0] row;

	modport source (output valid, output col, output row, input ready);
	modport sink (input valid, input col, input row, output ready);
endinterface

### design/jetp_out_if.sv
// Output channel carrying one pixel to draw and its colour per transaction.
// Depends on nothing.
interface jetp_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  out_col;
	logic [9:0]  out_row;
	logic [15:0] color;

	modport source (output valid, output out_col, output out_row, output color, input ready);
	modport sink (input valid, input out_col, input out_row, input color, output ready);
endinterface

### design/jetp_cfg_regs.sv
// Configuration register file for the Julia escape-time pixel block.
// Depends on jetp_pkg.
module jetp_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jetp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jetp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output jetp_pkg::cfg_t                    cfg
);

	jetp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width        <= jetp_pkg::RST_HALF_WIDTH;
			cfg_q.pixel_step        <= jetp_pkg::RST_PIXEL_STEP;
			cfg_q.attract_threshold <= jetp_pkg::RST_ATTRACT_THR;
			cfg_q.max_color         <= jetp_pkg::RST_MAX_COLOR;
			cfg_q.c_real            <= jetp_pkg::RST_C_REAL;
			cfg_q.c_imag            <= jetp_pkg::RST_C_IMAG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jetp_pkg::CFG_HALF_WIDTH:  cfg_q.half_width        <= cfg_wdata[30:0];
				jetp_pkg::CFG_PIXEL_STEP:  cfg_q.pixel_step        <= cfg_wdata[30:0];
				jetp_pkg::CFG_ATTRACT_THR: cfg_q.attract_threshold <= cfg_wdata[30:0];
				jetp_pkg::CFG_MAX_COLOR:   cfg_q.max_color         <= cfg_wdata[15:0];
				jetp_pkg::CFG_C_REAL:      cfg_q.c_real            <= $signed(cfg_wdata);
				jetp_pkg::CFG_C_IMAG:      cfg_q.c_imag            <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/jetp_mul.sv
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// Depends on nothing.
module jetp_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p
);

	logic signed [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### design/jetp_core.sv
// Sequencer and datapath for the escape-time iteration around the shared multiplier.
// Depends on jetp_pkg, jetp_mul, jetp_in_if and jetp_out_if.
module jetp_core #(
	parameter int SCREEN_SIZE = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  jetp_pkg::cfg_t cfg,
	jetp_in_if.sink        pix_in,
	jetp_out_if.source     pix_out
);

	typedef enum logic [3:0] {
		S_IDLE, S_X0, S_Y0, S_Y0W, S_XX, S_YY, S_XY, S_UPD, S_EMIT
	} state_t;

	state_t             state_q;
	logic [9:0]         col_q;
	logic [9:0]         row_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [63:0] xx_q;
	logic signed [63:0] diff_q;
	logic [16:0]        count_q;
	logic               first_q;
	logic               out_valid_q;
	logic [9:0]         out_col_q;
	logic [9:0]         out_row_q;
	logic [15:0]        color_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod;
	logic signed [63:0] hw_ext;
	logic [63:0]        mag;
	logic [63:0]        attract;
	logic [16:0]        limit;
	logic               off_screen;
	logic signed [31:0] nx;
	logic signed [31:0] ny;

	jetp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_comb begin
		unique case (state_q)
			S_X0: begin
				mul_a = $signed({1'b0, cfg.pixel_step});
				mul_b = $signed({22'b0, col_q});
			end
			S_Y0: begin
				mul_a = $signed({1'b0, cfg.pixel_step});
				mul_b = $signed({22'b0, row_q});
			end
			S_YY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			S_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = x_q;
			end
		endcase
	end

	assign hw_ext     = $signed({33'b0, cfg.half_width});
	// Both terms are squares and so non-negative; their sum fits 64 unsigned bits.
	assign mag        = $unsigned(xx_q) + $unsigned(prod);
	assign attract    = {9'b0, cfg.attract_threshold, 24'b0};
	assign limit      = {cfg.max_color, 1'b0};
	assign off_screen = (32'(pix_in.col) >= 32'(SCREEN_SIZE))
		|| (32'(pix_in.row) >= 32'(SCREEN_SIZE));
	// An arithmetic shift floors, so 2xy / 2^24 is the product shifted by 23.
	assign nx = jetp_pkg::sat32((diff_q >>> 24) + 64'(cfg.c_real));
	assign ny = jetp_pkg::sat32((prod >>> 23) + 64'(cfg.c_imag));

	assign pix_in.ready    = (state_q == S_IDLE);
	assign pix_out.valid   = out_valid_q;
	assign pix_out.out_col = out_col_q;
	assign pix_out.out_row = out_row_q;
	assign pix_out.color   = color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			first_q     <= 1'b1;
			count_q     <= '0;
		end else begin
			if (state_q == S_EMIT && (!out_valid_q || pix_out.ready)) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pix_in.valid) begin
						col_q <= pix_in.col;
						row_q <= pix_in.row;
						if (!off_screen) begin
							state_q <= S_X0;
						end
					end
				end
				S_X0: begin
					state_q <= S_Y0;
				end
				S_Y0: begin
					x_q     <= jetp_pkg::sat32(prod - hw_ext);
					state_q <= S_Y0W;
				end
				S_Y0W: begin
					y_q     <= jetp_pkg::sat32(hw_ext - prod);
					first_q <= 1'b1;
					count_q <= '0;
					state_q <= S_XX;
				end
				S_XX: begin
					state_q <= S_YY;
				end
				S_YY: begin
					xx_q    <= prod;
					state_q <= S_XY;
				end
				S_XY: begin
					// The squares of the current point are also its magnitude test, except for the start point.
					diff_q <= xx_q - prod;
					if (first_q) begin
						state_q <= S_UPD;
					end else if (mag < attract) begin
						state_q <= S_IDLE;
					end else if (mag >= jetp_pkg::ESCAPE_MAG || count_q >= limit) begin
						state_q <= S_EMIT;
					end else begin
						count_q <= count_q + 17'd1;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					x_q     <= nx;
					y_q     <= ny;
					first_q <= 1'b0;
					state_q <= S_XX;
				end
				S_EMIT: begin
					if (!out_valid_q || pix_out.ready) begin
						out_col_q   <= col_q;
						out_row_q   <= row_q;
						color_q     <= count_q[16:1];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/julia_escape_time_pixel_top.sv
// Julia-set escape-time pixel classifier. One pixel (col, row) is taken per
// transaction and mapped to a start point in Q8.24; z is iterated as z*z + c on
// a single shared 32 x 32 multiplier. Each iteration runs three multiplies
// (x*x, y*y, x*y) and an update, with the magnitude test folded into the
// multiply of x*y. A pixel that escapes or reaches the iteration limit gives its
// result through the emit step; an attracted pixel skips that step and gives
// nothing, and an off-screen pixel is dropped in its accepting cycle. The input
// is not ready while a pixel is being iterated; a result waits in an output
// register, so the next pixel can be taken while the previous result is pending.
// Depends on jetp_pkg, jetp_in_if, jetp_out_if, jetp_cfg_regs and jetp_core.
module julia_escape_time_pixel_top #(
	parameter int SCREEN_SIZE = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	jetp_in_if.sink                         pix_in,
	jetp_out_if.source                      pix_out,
	input  logic                            cfg_we,
	input  logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jetp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	jetp_pkg::cfg_t cfg;

	jetp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	jetp_core #(
		.SCREEN_SIZE (SCREEN_SIZE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

endmodule

### bench/tb_julia_escape_time_pixel_top.sv
// Self-checking bench for julia_escape_time_pixel_top: pixels are driven through the input
// channel and every drawn pixel is checked against an in-bench escape-time predictor.
// Depends on jetp_pkg, jetp_in_if, jetp_out_if and the top level of the block.
module tb_julia_escape_time_pixel_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN_SIZE = 1024;
	localparam logic [jetp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [jetp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam logic [63:0] ESCAPE_Q1648 = 64'd100 << 48;
	localparam longint signed Q_MAX = 64'sd2147483647;
	localparam longint signed Q_MIN = -64'sd2147483648;

	typedef struct {
		logic [9:0]  col;
		logic [9:0]  row;
		logic [15:0] color;
	} pixel_result_t;

	class pixel_scoreboard;
		jetp_pkg::cfg_t  regs;
		pixel_result_t   drawn_q[$];
		int unsigned     mismatches;

		function new();
			regs.half_width        = jetp_pkg::RST_HALF_WIDTH;
			regs.pixel_step        = jetp_pkg::RST_PIXEL_STEP;
			regs.attract_threshold = jetp_pkg::RST_ATTRACT_THR;
			regs.max_color         = jetp_pkg::RST_MAX_COLOR;
			regs.c_real            = jetp_pkg::RST_C_REAL;
			regs.c_imag            = jetp_pkg::RST_C_IMAG;
			mismatches             = 0;
		endfunction

		function void set_reg(logic [jetp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				jetp_pkg::CFG_HALF_WIDTH:  regs.half_width = data[30:0];
				jetp_pkg::CFG_PIXEL_STEP:  regs.pixel_step = data[30:0];
				jetp_pkg::CFG_ATTRACT_THR: regs.attract_threshold = data[30:0];
				jetp_pkg::CFG_MAX_COLOR:   regs.max_color = data[15:0];
				jetp_pkg::CFG_C_REAL:      regs.c_real = data;
				jetp_pkg::CFG_C_IMAG:      regs.c_imag = data;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return drawn_q.size();
		endfunction

		function logic signed [31:0] clamp_q(longint signed v);
			if (v > Q_MAX) return Q_MAX[31:0];
			if (v < Q_MIN) return Q_MIN[31:0];
			return v[31:0];
		endfunction

		// Returns 1 when the pixel is drawn; color is then the escape count halved.
		function bit escape_color(logic [9:0] col, logic [9:0] row, output logic [15:0] color);
			longint signed     sq_x, sq_y, prod_xy;
			logic signed [31:0] x, y, x_next, y_next;
			logic [31:0]        ax, ay;
			logic [63:0]        mag, attract;
			int unsigned        limit, count;
			color = '0;
			if (col >= SCREEN_SIZE || row >= SCREEN_SIZE) return 1'b0;
			limit   = 2 * regs.max_color;
			count   = 0;
			attract = {33'd0, regs.attract_threshold} << 24;
			x = clamp_q(longint'(regs.pixel_step) * longint'(col) - longint'(regs.half_width));
			y = clamp_q(longint'(regs.half_width) - longint'(regs.pixel_step) * longint'(row));
			while (1'b1) begin
				sq_x    = longint'(x) * longint'(x);
				sq_y    = longint'(y) * longint'(y);
				prod_xy = longint'(x) * longint'(y);
				x_next  = clamp_q(((sq_x - sq_y) >>> 24) + longint'(regs.c_real));
				y_next  = clamp_q((prod_xy >>> 23) + longint'(regs.c_imag));
				x      = x_next;
				y      = y_next;
				ax     = x[31] ? -x : x;
				ay     = y[31] ? -y : y;
				mag    = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
				if (mag < attract) return 1'b0;
				if (mag < ESCAPE_Q1648 && count < limit) begin
					count++;
				end else begin
					color = 16'(count / 2);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_pixel(logic [9:0] col, logic [9:0] row);
			pixel_result_t want;
			want.col = col;
			want.row = row;
			if (escape_color(col, row, want.color)) drawn_q.push_back(want);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 50) $display("ERROR at %0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [9:0] col, logic [9:0] row, logic [15:0] color);
			pixel_result_t want;
			if (drawn_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel (%0d,%0d) color %0d", col, row, color));
				return;
			end
			want = drawn_q.pop_front();
			if (col !== want.col)
				report_mismatch($sformatf("out_col %0d, expected %0d", col, want.col));
			if (row !== want.row)
				report_mismatch($sformatf("out_row %0d, expected %0d", row, want.row));
			if (color !== want.color)
				report_mismatch($sformatf("color %0d, expected %0d for pixel (%0d,%0d)",
					color, want.color, want.col, want.row));
		endtask
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [jetp_pkg::CFG_DATA_W-1:0] cfg_wdata;
	int unsigned                     src_idle_pct;
	int unsigned                     sink_stall_pct;
	pixel_scoreboard                 sb;

	jetp_in_if  pix_in ();
	jetp_out_if pix_out ();

	julia_escape_time_pixel_top #(
		.SCREEN_SIZE(SCREEN_SIZE)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		pix_out.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pix_in.valid === 1'b1 && pix_in.ready === 1'b1)
			sb.note_pixel(pix_in.col, pix_in.row);
	end

	always @(posedge clk) begin
		if (arst_n && pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
			sb.check_result(pix_out.out_col, pix_out.out_row, pix_out.color);
	end

	// All driving tasks start and end just after a falling edge.
	task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.col   <= col;
		pix_in.row   <= row;
		do @(posedge clk); while (pix_in.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Holds the input off until every drawn pixel has come out and the block
	// has finished any pixel that is being attracted.
	task automatic settle();
		int unsigned waited;
		pix_in.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pix_in.ready !== 1'b1 && waited < 8 * sb.regs.max_color + 16);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [jetp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_regs(input logic [31:0] hw, input logic [31:0] step,
	                         input logic [31:0] thr, input logic [31:0] mc,
	                         input logic [31:0] cr, input logic [31:0] ci);
		write_reg(jetp_pkg::CFG_HALF_WIDTH, hw);
		write_reg(jetp_pkg::CFG_PIXEL_STEP, step);
		write_reg(jetp_pkg::CFG_ATTRACT_THR, thr);
		write_reg(jetp_pkg::CFG_MAX_COLOR, mc);
		write_reg(jetp_pkg::CFG_C_REAL, cr);
		write_reg(jetp_pkg::CFG_C_IMAG, ci);
		// Writes past the register list must leave every setting alone.
		write_reg(CFG_SPARE_A, $urandom());
		write_reg(CFG_SPARE_B, $urandom());
		cfg_we <= 1'b0;
	endtask

	task automatic random_regs(input int unsigned phase);
		logic [31:0] hw, step;
		if (phase == 5) begin
			// Widest iteration limit; a huge positive c makes nearly every orbit escape
			// within a few steps, so the run stays short.
			load_regs($urandom(), $urandom(), $urandom(), {16'($urandom()), 16'hFFFF},
				32'h7F00_0000 + 32'($urandom_range(32'h00FF_FFFF)), $urandom());
		end else if (phase % 3 == 2) begin
			load_regs($urandom(), $urandom(), $urandom(),
				{16'($urandom()), 16'($urandom_range(32))}, $urandom(), $urandom());
		end else begin
			hw   = $urandom_range(32'h0300_0000, 32'h0080_0000);
			step = hw * 2 / $urandom_range(1024, 128);
			load_regs(hw, step, $urandom_range(32'h4000), $urandom_range(32, 1),
				32'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
				32'($urandom_range(32'h0200_0000)) - 32'h0100_0000);
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		pix_in.valid  = 1'b0;
		pix_in.col    = '0;
		pix_in.row    = '0;
		pix_out.ready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		src_idle_pct  = 0;
		sink_stall_pct = 0;
	end

	initial begin
		int unsigned phase, n, pause_at;
		logic [9:0]  col, row;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Settings straight out of reset, corners and alternating bit patterns.
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'h155, 10'h2AA);
		send_pixel(10'h2AA, 10'h155);
		send_pixel(10'd240, 10'd240);
		send_pixel(10'd256, 10'd256);
		settle();

		// A zero colour count: anything not attracted escapes at once.
		load_regs(32'h0200_0000, 32'd140102, 32'd1678, 32'd0, 32'hFFE0_C49C, 32'h00BE_B852);
		send_pixel(10'd100, 10'd100);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd240, 10'd240);
		settle();

		// Everything but the colour count zero: z stays at the origin and runs to the iteration limit.
		load_regs(32'd0, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		settle();

		// A unit threshold with c at zero: points inside the unit circle are attracted.
		load_regs(32'h0100_0000, 32'd32768, 32'h0100_0000, 32'd15, 32'd0, 32'd0);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd600, 10'd400);
		send_pixel(10'd0, 10'd0);
		settle();

		// Saturation on every side; the top bit of the 31-bit registers is dropped.
		load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd15,
			32'h8000_0000, 32'h7FFF_FFFF);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1, 10'd0);
		send_pixel(10'd0, 10'd1);
		settle();

		load_regs(32'h0200_0000, 32'd140102, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd512, 10'd300);
		send_pixel(10'd1023, 10'd1023);
		settle();

		for (phase = 0; phase < 12; phase++) begin
			case (phase % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
				default: begin src_idle_pct = 34; sink_stall_pct = 34; end
			endcase
			random_regs(phase);
			pause_at = $urandom_range(50, 10);
			for (n = 0; n < 62; n++) begin
				if (n == pause_at) settle();
				if ($urandom_range(7) == 0) begin
					col = $urandom_range(1) ? 10'd1023 : 10'd0;
					row = $urandom_range(1) ? 10'd1023 : 10'd0;
				end else begin
					col = 10'($urandom_range(1023));
					row = 10'($urandom_range(1023));
				end
				send_pixel(col, row);
			end
			settle();
		end

		repeat (64) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("julia_escape_time_pixel_top test passed");
		end else begin
			$display("julia_escape_time_pixel_top test failed");
		end
		$finish;
	end

	initial begin
		#80ms;
		$display("julia_escape_time_pixel_top test failed");
		$finish;
	end

endmodule
